[rtl/aqss_pkg.sv]
// ----------------------------------------------------------------------------
// aqss_pkg
// Shared constants, operation and status codes, and divider interface types
// for the array queue with search and statistics.
// ----------------------------------------------------------------------------
package aqss_pkg;

  localparam int DEPTH = 32;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SUMW  = 32 + $clog2(DEPTH);
  localparam int DW    = SUMW + 8;

  localparam logic [2:0] OP_ENQ   = 3'd0;
  localparam logic [2:0] OP_DEQ   = 3'd1;
  localparam logic [2:0] OP_FIND  = 3'd2;
  localparam logic [2:0] OP_EDIT  = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;
  localparam logic [2:0] OP_STATS = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_RANGE    = 3'd4;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] dividend;
    logic [CW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/aqss_div.sv]
// ----------------------------------------------------------------------------
// aqss_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aqss_div
  import aqss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int NW = $clog2(DW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] q_r, q_nxt;
  logic [CW-1:0] dvs_r, dvs_nxt;
  logic [CW:0]   rem_r, rem_nxt;
  logic [CW:0]   rem_sh;
  logic [CW:0]   diff;

  always_comb begin
    rem_sh   = {rem_r[CW-1:0], q_r[DW-1]};
    diff     = rem_sh - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = NW'(DW);
      q_nxt    = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = diff;
        q_nxt   = {q_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == NW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

[rtl/array_queue_with_search_and_stats.sv]
// ----------------------------------------------------------------------------
// array_queue_with_search_and_stats
// Circular-buffer FIFO of signed words with find, edit, clear and statistics.
// ----------------------------------------------------------------------------
// Usage: one input item (in_valid/in_ready) carries one operation; exactly one
// result item (out_valid/out_ready) comes back per input item, in order.
// in_ready is high only while the sequencer is idle, so one item is worked at
// a time. Enqueue, edit, clear, unused codes and any empty case go from the
// execute step straight to the result; dequeue reads the front entry, find
// scans the held entries, and statistics scans them and then divides (the
// dividend is DW = 45 bits wide at depth 32).
// The scan reads one entry per cycle through the single read port of the
// entry memory; the average comes from a one-bit-per-cycle divider.
// The result sits in an output register; while the receiver stalls the next
// item may be accepted and worked, and it waits at the end for the register.
// Reset empties the queue (front and count to zero) and drops any result in
// flight. Entry storage is not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
module array_queue_with_search_and_stats
  import aqss_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_operation,
  input  logic signed [31:0] in_value,
  input  logic [4:0]         in_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_word,
  output logic [4:0]         out_position,
  output logic [5:0]         out_occupancy,
  output logic signed [36:0] out_total,
  output logic signed [31:0] out_largest,
  output logic signed [31:0] out_smallest,
  output logic signed [39:0] out_average_q8
);

  localparam int SW = CW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]             st_r, st_nxt;
  logic [2:0]             op_r, op_nxt;
  logic [31:0]            val_r, val_nxt;
  logic [4:0]             idx_r, idx_nxt;
  logic [AW-1:0]          front_r, front_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          k_r, k_nxt;
  logic [CW-1:0]          len_r, len_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]          rd_idx_r, rd_idx_nxt;
  logic [31:0]            rd_data_r;
  logic                   found_r, found_nxt;
  logic                   neg_r, neg_nxt;
  logic [2:0]             sts_r, sts_nxt;
  logic [31:0]            word_r, word_nxt;
  logic [4:0]             pos_r, pos_nxt;
  logic signed [SUMW-1:0] sum_r, sum_nxt;
  logic signed [31:0]     mx_r, mx_nxt;
  logic signed [31:0]     mn_r, mn_nxt;
  logic signed [39:0]     avg_r, avg_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   load;

  logic [31:0]            mem [DEPTH];
  logic                   we;
  logic [AW-1:0]          wa;
  logic [AW-1:0]          ra;
  logic signed [31:0]     e;
  logic [SUMW-1:0]        mag;
  logic signed [DW:0]     qs;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(DEPTH)) s = s - SW'(DEPTH);
    return AW'(s);
  endfunction

  assign e   = signed'(rd_data_r);
  assign mag = sum_r[SUMW-1] ? unsigned'(-sum_r) : unsigned'(sum_r);
  assign qs  = signed'({1'b0, div_rsp.quotient});
  assign ra  = slot(front_r, k_r);

  assign in_ready = (st_r == S_IDLE);

  always_comb begin
    st_nxt        = st_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    len_nxt       = len_r;
    rd_vld_nxt    = rd_vld_r;
    rd_idx_nxt    = rd_idx_r;
    found_nxt     = found_r;
    neg_nxt       = neg_r;
    sts_nxt       = sts_r;
    word_nxt      = word_r;
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    mx_nxt        = mx_r;
    mn_nxt        = mn_r;
    avg_nxt       = avg_r;
    we            = 1'b0;
    wa            = slot(front_r, count_r);
    div_req.start    = 1'b0;
    div_req.dividend = {mag, 8'd0};
    div_req.divisor  = count_r;
    load          = 1'b0;

    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_operation;
          val_nxt = in_value;
          idx_nxt = in_index;
          st_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        sts_nxt    = ST_OK;
        word_nxt   = '0;
        pos_nxt    = '0;
        sum_nxt    = '0;
        mx_nxt     = '0;
        mn_nxt     = '0;
        avg_nxt    = '0;
        found_nxt  = 1'b0;
        k_nxt      = '0;
        rd_vld_nxt = 1'b0;
        len_nxt    = count_r;
        st_nxt     = S_DONE;
        case (op_r)
          OP_ENQ: begin
            if (count_r >= CW'(DEPTH)) begin
              sts_nxt = ST_FULL;
            end else begin
              we        = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
          OP_DEQ: begin
            if (count_r == '0) begin
              sts_nxt = ST_EMPTY;
            end else begin
              len_nxt = CW'(1);
              st_nxt  = S_SCAN;
            end
          end
          OP_FIND, OP_STATS: begin
            if (count_r == '0) sts_nxt = ST_EMPTY;
            else st_nxt = S_SCAN;
          end
          OP_EDIT: begin
            if (count_r == '0) begin
              sts_nxt = ST_EMPTY;
            end else if (32'(idx_r) >= 32'(count_r)) begin
              sts_nxt = ST_RANGE;
            end else begin
              we = 1'b1;
              wa = slot(front_r, CW'(idx_r));
            end
          end
          OP_CLEAR: begin
            front_nxt = '0;
            count_nxt = '0;
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        // read of entry k issues here, its data is handled in the following cycle
        rd_vld_nxt = 1'b0;
        if (k_r < len_r) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = AW'(k_r);
          k_nxt      = k_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (rd_idx_r == '0) begin
            word_nxt = rd_data_r;
            mx_nxt   = e;
            mn_nxt   = e;
          end else begin
            if (e > mx_r) mx_nxt = e;
            if (e < mn_r) mn_nxt = e;
          end
          sum_nxt = sum_r + SUMW'(e);
          if (!found_r && rd_data_r == val_r) begin
            found_nxt = 1'b1;
            pos_nxt   = 5'(rd_idx_r);
          end
        end
        if (k_r == len_r && !rd_vld_r) begin
          case (op_r)
            OP_DEQ: begin
              front_nxt = slot(front_r, CW'(1));
              count_nxt = count_r - 1'b1;
              pos_nxt   = '0;
              sum_nxt   = '0;
              mx_nxt    = '0;
              mn_nxt    = '0;
              st_nxt    = S_DONE;
            end
            OP_FIND: begin
              sts_nxt  = found_r ? ST_OK : ST_NOTFOUND;
              word_nxt = '0;
              sum_nxt  = '0;
              mx_nxt   = '0;
              mn_nxt   = '0;
              st_nxt   = S_DONE;
            end
            default: begin
              word_nxt      = '0;
              pos_nxt       = '0;
              neg_nxt       = sum_r[SUMW-1];
              div_req.start = 1'b1;
              st_nxt        = S_DIV;
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          avg_nxt = neg_r ? 40'(-qs) : 40'(qs);
          st_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          load   = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r && !out_ready;
    if (load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= val_r;
    rd_data_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    idx_r    <= idx_nxt;
    k_r      <= k_nxt;
    len_r    <= len_nxt;
    rd_idx_r <= rd_idx_nxt;
    found_r  <= found_nxt;
    neg_r    <= neg_nxt;
    sts_r    <= sts_nxt;
    word_r   <= word_nxt;
    pos_r    <= pos_nxt;
    sum_r    <= sum_nxt;
    mx_r     <= mx_nxt;
    mn_r     <= mn_nxt;
    avg_r    <= avg_nxt;
    if (load) begin
      out_status     <= sts_r;
      out_word       <= signed'(word_r);
      out_position   <= pos_r;
      out_occupancy  <= 6'(count_r);
      out_total      <= 37'(sum_r);
      out_largest    <= mx_r;
      out_smallest   <= mn_r;
      out_average_q8 <= avg_r;
    end
  end

  assign out_valid = out_valid_r;

  aqss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("occupancy beyond depth");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while busy");

  a_div_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (st_r == S_SCAN && op_r == OP_STATS))
    else $error("divider started outside statistics scan");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_smallest <= out_largest))
    else $error("smallest above largest");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status == ST_EMPTY) |-> (out_occupancy == 6'd0))
    else $error("empty status with entries held");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status == ST_FULL) |-> (out_occupancy == 6'(DEPTH)))
    else $error("full status below depth");

endmodule
